// ===== src/heartbeat_liveness_gate_macros.svh =====
// ----------------------------------------------------------------------------
// heartbeat_liveness_gate_macros.svh
// Assertion macros used by the liveness gate checker.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_LIVENESS_GATE_MACROS_SVH
`define HEARTBEAT_LIVENESS_GATE_MACROS_SVH

// Property checked at every rising clock edge, masked while reset is high.
`define HLG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define HLG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/hlg_pkg.sv =====
// ----------------------------------------------------------------------------
// hlg_pkg
// Types, register indexes and reset values of the heartbeat liveness gate.
// ----------------------------------------------------------------------------
package hlg_pkg;

   localparam int unsigned RR_W    = 16;
   localparam int unsigned BPM_W   = 8;
   localparam int unsigned CNT_W   = 8;
   localparam int unsigned CSR_A_W = 3;
   localparam int unsigned CSR_D_W = 16;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // register indexes
   localparam logic [CSR_A_W-1:0] CSR_MAX_DELTA   = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_TRANS_NEED  = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_BPM_MIN     = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_BPM_MAX     = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_BAD_LIMIT   = 3'd4;

   // register reset values
   localparam logic [RR_W-1:0]  RST_MAX_DELTA  = 16'd250;
   localparam logic [CNT_W-1:0] RST_TRANS_NEED = 8'd5;
   localparam logic [BPM_W-1:0] RST_BPM_MIN    = 8'd30;
   localparam logic [BPM_W-1:0] RST_BPM_MAX    = 8'd220;
   localparam logic [CNT_W-1:0] RST_BAD_LIMIT  = 8'd1;

   typedef struct packed {
      logic             kind;
      logic [BPM_W-1:0] bpm;
      logic             rr_present;
      logic [RR_W-1:0]  rr_ms;
      logic             arming;
      logic             phone_active;
      logic             recording;
      logic             transition_busy;
   } req_item_type;

   typedef struct packed {
      logic             pulse_found;
      logic             tick_alive;
      logic             stop_request;
      logic [CNT_W-1:0] alive_now;
      logic [CNT_W-1:0] wild_now;
   } rsp_item_type;

   typedef struct packed {
      logic [CSR_A_W-1:0] index;
      logic [CSR_D_W-1:0] data;
   } csr_item_type;

   // configuration bundle handed to the datapath
   typedef struct packed {
      logic [RR_W-1:0]  max_delta_ms;
      logic [CNT_W-1:0] transitions_needed;
      logic [BPM_W-1:0] bpm_min;
      logic [BPM_W-1:0] bpm_max;
      logic [CNT_W-1:0] bad_tick_limit;
   } cfg_type;

endpackage

// ===== src/hlg_ifs.sv =====
// ----------------------------------------------------------------------------
// hlg_ifs
// Valid/ready channels of the heartbeat liveness gate.
// ----------------------------------------------------------------------------
interface hlg_req_if;
   logic                  valid;
   logic                  ready;
   hlg_pkg::req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface hlg_rsp_if;
   logic                  valid;
   logic                  ready;
   hlg_pkg::rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface hlg_csr_if;
   logic                        valid;
   logic                        ready;
   logic [hlg_pkg::CSR_A_W-1:0] index;
   logic [hlg_pkg::CSR_D_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/hlg_csr.sv =====
// ----------------------------------------------------------------------------
// hlg_csr
// Configuration registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module hlg_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_valid,
   input  logic [hlg_pkg::CSR_A_W-1:0] wr_index,
   input  logic [hlg_pkg::CSR_D_W-1:0] wr_data,
   output hlg_pkg::cfg_type            cfg
);

   hlg_pkg::cfg_type cfg_ff;
   hlg_pkg::cfg_type cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            hlg_pkg::CSR_MAX_DELTA:  cfg_in.max_delta_ms       = wr_data;
            hlg_pkg::CSR_TRANS_NEED: cfg_in.transitions_needed = wr_data[hlg_pkg::CNT_W-1:0];
            hlg_pkg::CSR_BPM_MIN:    cfg_in.bpm_min            = wr_data[hlg_pkg::BPM_W-1:0];
            hlg_pkg::CSR_BPM_MAX:    cfg_in.bpm_max            = wr_data[hlg_pkg::BPM_W-1:0];
            hlg_pkg::CSR_BAD_LIMIT:  cfg_in.bad_tick_limit     = wr_data[hlg_pkg::CNT_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_delta_ms       <= hlg_pkg::RST_MAX_DELTA;
         cfg_ff.transitions_needed <= hlg_pkg::RST_TRANS_NEED;
         cfg_ff.bpm_min            <= hlg_pkg::RST_BPM_MIN;
         cfg_ff.bpm_max            <= hlg_pkg::RST_BPM_MAX;
         cfg_ff.bad_tick_limit     <= hlg_pkg::RST_BAD_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/hlg_core.sv =====
// ----------------------------------------------------------------------------
// hlg_core
// Input register, liveness state and the per-item judgement logic.
// ----------------------------------------------------------------------------
module hlg_core (
   input  logic                  clock,
   input  logic                  reset,
   input  hlg_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   input  hlg_pkg::req_item_type in_item,
   output logic                  in_ready,
   output logic                  res_valid,
   output hlg_pkg::rsp_item_type res_item,
   input  logic                  res_ready
);

   logic                         hold_valid_ff, hold_valid_in;
   hlg_pkg::req_item_type        hold_item_ff;
   logic [hlg_pkg::RR_W-1:0]     last_ff, last_in;
   logic [hlg_pkg::CNT_W-1:0]    alive_ff, alive_in;
   logic [hlg_pkg::CNT_W-1:0]    wild_ff, wild_in;
   logic                         seen_ff, seen_in;
   logic [hlg_pkg::CNT_W-1:0]    bad_ff, bad_in;

   logic                         fire;
   logic                         is_tick;
   logic [hlg_pkg::RR_W-1:0]     delta;
   logic                         has_prev;
   logic                         alive_step;
   logic                         wild_step;
   logic [hlg_pkg::CNT_W-1:0]    alive_smp;
   logic [hlg_pkg::CNT_W-1:0]    wild_smp;
   logic                         bpm_ok;
   logic                         smp_alive;
   logic                         tick_ok;
   logic [hlg_pkg::CNT_W-1:0]    bad_tick;

   // input register moves on when the result stage takes it
   assign fire     = hold_valid_ff && res_ready;
   assign in_ready = !hold_valid_ff || res_ready;
   assign hold_valid_in = in_ready ? in_valid : hold_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hold_item_ff <= in_item;
      end
   end

   // interval change against the previous interval
   assign is_tick  = (hold_item_ff.kind == hlg_pkg::KIND_TICK);
   assign delta    = (hold_item_ff.rr_ms >= last_ff) ? (hold_item_ff.rr_ms - last_ff)
                                                     : (last_ff - hold_item_ff.rr_ms);
   assign has_prev = hold_item_ff.rr_present && (last_ff != '0);
   assign alive_step = has_prev && (delta != '0) && (delta <= cfg.max_delta_ms);
   assign wild_step  = has_prev && (delta > cfg.max_delta_ms);
   assign alive_smp = (alive_step && alive_ff != hlg_pkg::CNT_MAX) ? alive_ff + 1'b1
                                                                 : alive_ff;
   assign wild_smp  = (wild_step && wild_ff != hlg_pkg::CNT_MAX) ? wild_ff + 1'b1 : wild_ff;

   // gate on the sample, judging the period on updated counts
   assign bpm_ok    = (hold_item_ff.bpm >= cfg.bpm_min) && (hold_item_ff.bpm <= cfg.bpm_max);
   assign smp_alive = (alive_smp >= cfg.transitions_needed) && (alive_smp > wild_smp);

   // tick judgement on the counts of the closing period
   assign tick_ok  = seen_ff && (alive_ff >= cfg.transitions_needed) && (alive_ff > wild_ff);
   assign bad_tick = tick_ok ? '0 :
                     (bad_ff != hlg_pkg::CNT_MAX) ? bad_ff + 1'b1 : bad_ff;

   // result and next state
   always_comb begin
      res_item = '0;
      last_in  = last_ff;
      alive_in = alive_ff;
      wild_in  = wild_ff;
      seen_in  = seen_ff;
      bad_in   = bad_ff;
      if (is_tick) begin
         res_item.tick_alive   = tick_ok;
         res_item.stop_request = !tick_ok && (bad_tick >= cfg.bad_tick_limit)
                                 && hold_item_ff.recording && !hold_item_ff.transition_busy;
         alive_in = '0;
         wild_in  = '0;
         seen_in  = 1'b0;
         bad_in   = bad_tick;
      end else begin
         res_item.pulse_found = hold_item_ff.arming && !hold_item_ff.phone_active
                                && bpm_ok && smp_alive;
         res_item.alive_now   = alive_smp;
         res_item.wild_now    = wild_smp;
         alive_in = alive_smp;
         wild_in  = wild_smp;
         if (hold_item_ff.rr_present) begin
            last_in = hold_item_ff.rr_ms;
         end
         if (bpm_ok) begin
            seen_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         alive_ff <= '0;
         wild_ff  <= '0;
         seen_ff  <= 1'b0;
         bad_ff   <= '0;
      end else if (fire) begin
         last_ff  <= last_in;
         alive_ff <= alive_in;
         wild_ff  <= wild_in;
         seen_ff  <= seen_in;
         bad_ff   <= bad_in;
      end
   end

   assign res_valid = hold_valid_ff;

endmodule

// ===== src/hlg_out.sv =====
// ----------------------------------------------------------------------------
// hlg_out
// Result register between the judgement logic and the response channel.
// ----------------------------------------------------------------------------
module hlg_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  hlg_pkg::rsp_item_type res_item,
   output logic                  res_ready,
   output logic                  rsp_valid,
   output hlg_pkg::rsp_item_type rsp_item,
   input  logic                  rsp_ready
);

   logic                  valid_ff, valid_in;
   hlg_pkg::rsp_item_type item_ff;

   // load whenever the register is empty or being drained
   assign res_ready = !valid_ff || rsp_ready;
   assign valid_in  = res_ready ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         item_ff <= res_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// ===== src/heartbeat_liveness_gate.sv =====
// ----------------------------------------------------------------------------
// heartbeat_liveness_gate
// Judges heart-rate samples and watchdog ticks for signs of a live pulse.
// ----------------------------------------------------------------------------
// channel  | dir | payload                                   | handshake
// req_ch   | in  | kind, bpm, rr_present, rr_ms, arming,     | valid/ready
//          |     | phone_active, recording, transition_busy  |
// rsp_ch   | out | pulse_found, tick_alive, stop_request,    | valid/ready
//          |     | alive_now, wild_now                       |
// csr_ch   | in  | index, data                               | valid/ready
//
// One item per cycle sustained while rsp_ch is ready; an item's result passes
// through the input register, then the result register.
// The state update is combinational compare-and-count logic.
// Synchronous reset restores register defaults and clears all counters.
// A stalled response holds its register; new items keep flowing until both
// registers are full. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module heartbeat_liveness_gate (
   input logic       clock,
   input logic       reset,
   hlg_req_if.sink   req_ch,
   hlg_rsp_if.source rsp_ch,
   hlg_csr_if.sink   csr_ch
);

   hlg_pkg::cfg_type      cfg;
   logic                  res_valid;
   logic                  res_ready;
   hlg_pkg::rsp_item_type res_item;

   assign csr_ch.ready = 1'b1;

   hlg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   hlg_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_ch.valid),
      .in_item   (req_ch.item),
      .in_ready  (req_ch.ready),
      .res_valid (res_valid),
      .res_item  (res_item),
      .res_ready (res_ready)
   );

   hlg_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_item  (res_item),
      .res_ready (res_ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_item  (rsp_ch.item),
      .rsp_ready (rsp_ch.ready)
   );

endmodule

// ===== src/hlg_checker.sv =====
// ----------------------------------------------------------------------------
// hlg_checker
// Port-level checks of the liveness gate, bound to the top level.
// ----------------------------------------------------------------------------
`include "heartbeat_liveness_gate_macros.svh"

module hlg_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input hlg_pkg::rsp_item_type rsp_item
);

   // a waiting result stays offered
   `HLG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped while stalled")

   // sample flags and tick flags never share an item
   `HLG_ASSERT(a_kind_excl, clock, reset, rsp_valid |-> !(rsp_item.pulse_found && (rsp_item.tick_alive || rsp_item.stop_request)), "sample and tick flags together")

   // a live period never asks for a stop
   `HLG_ASSERT(a_alive_nostop, clock, reset, rsp_valid |-> !(rsp_item.tick_alive && rsp_item.stop_request), "stop on a live tick")

   // tick results report cleared counters
   `HLG_ASSERT(a_tick_clear, clock, reset, rsp_valid && (rsp_item.tick_alive || rsp_item.stop_request) |-> (rsp_item.alive_now == '0) && (rsp_item.wild_now == '0), "counters not cleared on tick")

   // nothing offered right after reset
   `HLG_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "rsp valid after reset")

endmodule

bind heartbeat_liveness_gate hlg_checker u_hlg_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_item  (rsp_ch.item)
);
